// ===== rtl/se_pkg.sv =====
package se_pkg;

  localparam int CP_W            = 21;
  localparam int LEN_W           = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 21;
  localparam int MAX_PATTERN_DEF = 6;
  localparam int CMD_DEPTH       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0      = 3'd1;

  typedef enum logic [0:0] {
    CMD_PASS,
    CMD_WINDOW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CP_W-1:0]   cp;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic              clear;
  } se_ctl_t;

  typedef enum logic [0:0] {
    ST_RUN,
    ST_FLUSH
  } back_state_t;

endpackage

// ===== rtl/se_fifo.sv =====
module se_fifo
  import se_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/se_front.sv =====
module se_front
  import se_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic                              push,
  input  logic [CP_W-1:0]                   in_code_point,
  input  logic                              in_end_of_string,
  output logic                              cmd_push,
  output cmd_t                              cmd,
  output se_ctl_t                           ctl,
  output logic [MAX_PATTERN-1:0][CP_W-1:0]  pattern
);

  logic [LEN_W-1:0]                  len_r;
  logic [MAX_PATTERN-1:0][CP_W-1:0]  pattern_r;
  logic [LEN_W-1:0]                  eff_len;

  assign eff_len = (len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_r;

  assign ctl.len   = eff_len;
  assign ctl.clear = cfg_we && (cfg_index == REG_PATTERN_LENGTH);
  assign pattern   = pattern_r;

  assign cmd_push = push;
  assign cmd.kind = (eff_len == '0) ? CMD_PASS : CMD_WINDOW;
  assign cmd.cp   = in_code_point;
  assign cmd.last = in_end_of_string;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      pattern_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_PATTERN_LENGTH) begin
        len_r <= cfg_data[LEN_W-1:0];
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (cfg_index == REG_PATTERN_0 + CFG_IDX_W'(i)) begin
          pattern_r[i] <= cfg_data[CP_W-1:0];
        end
      end
    end
  end

endmodule

// ===== rtl/se_back.sv =====
module se_back
  import se_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  cmd_t                              cmd,
  output logic                              cmd_pop,
  input  se_ctl_t                           ctl,
  input  logic [MAX_PATTERN-1:0][CP_W-1:0]  pattern,
  input  logic                              pop,
  output logic                              empty,
  output logic [CP_W-1:0]                   out_code_point,
  output logic                              out_has_char,
  output logic                              out_string_done
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  back_state_t      state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CP_W-1:0]  win_r [MAX_PATTERN];
  logic [CP_W-1:0]  win_nxt [MAX_PATTERN];
  logic [CP_W-1:0]  win_ins [MAX_PATTERN];
  logic [CP_W-1:0]  sh_ins [MAX_PATTERN];
  logic [CP_W-1:0]  sh_win [MAX_PATTERN];

  logic             out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]  out_cp_r, out_cp_nxt;
  logic             out_has_r, out_has_nxt;
  logic             out_done_r, out_done_nxt;

  logic             out_take, can_emit, match;
  logic [LEN_W-1:0] fill_inc;
  logic             emit;
  logic [CP_W-1:0]  e_cp;
  logic             e_has, e_done;

  assign empty           = !out_valid_r;
  assign out_code_point  = out_cp_r;
  assign out_has_char    = out_has_r;
  assign out_string_done = out_done_r;

  assign out_take = pop && out_valid_r;
  assign can_emit = !out_valid_r || out_take;
  assign fill_inc = LEN_W'(fill_r) + 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_ins[i] = (LEN_W'(i) == LEN_W'(fill_r)) ? cmd.cp : win_r[i];
    end
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      sh_ins[i] = win_ins[i + 1];
      sh_win[i] = win_r[i + 1];
    end
    sh_ins[MAX_PATTERN-1] = win_ins[MAX_PATTERN-1];
    sh_win[MAX_PATTERN-1] = win_r[MAX_PATTERN-1];
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < ctl.len) && (win_ins[i] != pattern[i])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    win_nxt   = win_r;
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    e_cp      = '0;
    e_has     = 1'b0;
    e_done    = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (cmd_valid && can_emit) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_PASS) begin
            emit   = 1'b1;
            e_cp   = cmd.cp;
            e_has  = 1'b1;
            e_done = cmd.last;
          end else if (fill_inc == ctl.len) begin
            if (match) begin
              fill_nxt = '0;
              if (cmd.last) begin
                emit   = 1'b1;
                e_done = 1'b1;
              end
            end else begin
              emit     = 1'b1;
              e_cp     = win_ins[0];
              e_has    = 1'b1;
              e_done   = cmd.last && (ctl.len == LEN_W'(1));
              win_nxt  = sh_ins;
              fill_nxt = FILL_W'(ctl.len - 1'b1);
              if (cmd.last && (ctl.len != LEN_W'(1))) begin
                state_nxt = ST_FLUSH;
              end
            end
          end else begin
            win_nxt  = win_ins;
            fill_nxt = FILL_W'(fill_inc);
            if (cmd.last) begin
              state_nxt = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_cp     = win_r[0];
          e_has    = 1'b1;
          e_done   = (fill_r == FILL_W'(1));
          win_nxt  = sh_win;
          fill_nxt = fill_r - 1'b1;
          if (fill_r == FILL_W'(1)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
    if (ctl.clear) begin
      fill_nxt  = '0;
      state_nxt = ST_RUN;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cp_nxt    = out_cp_r;
    out_has_nxt   = out_has_r;
    out_done_nxt  = out_done_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_cp_nxt    = e_cp;
      out_has_nxt   = e_has;
      out_done_nxt  = e_done;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    out_cp_r   <= out_cp_nxt;
    out_has_r  <= out_has_nxt;
    out_done_r <= out_done_nxt;
  end

`ifndef SYNTHESIS
  a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && ctl.len != '0) |-> (LEN_W'(fill_r) < ctl.len))
    else $error("window fill reached the pattern length while scanning");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> (fill_r != '0))
    else $error("flush entered with an empty window");

  a_flush_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && emit && fill_r == FILL_W'(1) && !ctl.clear)
      |=> (out_valid_r && out_string_done && out_has_char))
    else $error("last flushed entry did not close the string");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !e_has) |-> (e_done && e_cp == '0))
    else $error("bare end marker carries a code point");
`endif

endmodule

// ===== rtl/substring_eraser.sv =====
// Deletes every leftmost, non-overlapping occurrence of a pattern of up to
// MAX_PATTERN code points from a stream of strings, one code point per push.
// The front stage takes one item per cycle into a four-entry command queue
// unless it is full; the back stage retires one queued item per cycle via
// the window compare while its output is free or popped, so the sustained
// rate is one item per cycle. At a string's end the back stage flushes the
// window entries left over, up to the pattern length minus one, before the
// next item; the queue takes items meanwhile until it fills. Writing the
// pattern length drops buffered window entries; length zero is pass-through.
module substring_eraser
  import se_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [CP_W-1:0]        in_code_point,
  input  logic                   in_end_of_string,
  output logic                   empty,
  input  logic                   pop,
  output logic [CP_W-1:0]        out_code_point,
  output logic                   out_has_char,
  output logic                   out_string_done
);

  logic                              cmd_push;
  cmd_t                              front_cmd;
  cmd_t                              back_cmd;
  se_ctl_t                           ctl;
  logic [MAX_PATTERN-1:0][CP_W-1:0]  pattern;
  logic [$bits(cmd_t)-1:0]           fifo_rdata;
  logic                              cmd_valid;
  logic                              cmd_pop;

  se_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .in_code_point    (in_code_point),
    .in_end_of_string (in_end_of_string),
    .cmd_push         (cmd_push),
    .cmd              (front_cmd),
    .ctl              (ctl),
    .pattern          (pattern)
  );

  se_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (fifo_rdata),
    .valid   (cmd_valid)
  );

  assign back_cmd = cmd_t'(fifo_rdata);

  se_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (back_cmd),
    .cmd_pop         (cmd_pop),
    .ctl             (ctl),
    .pattern         (pattern),
    .pop             (pop),
    .empty           (empty),
    .out_code_point  (out_code_point),
    .out_has_char    (out_has_char),
    .out_string_done (out_string_done)
  );

endmodule
